// ----- rtl/fqs_pkg.sv -----
// ----------------------------------------------------------------------------
// fqs_pkg
// Request and response types and operation/status codes for the FIFO queue
// with linear search.
// ----------------------------------------------------------------------------
package fqs_pkg;

    localparam int VALUE_W = 32;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_FIND   = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_MISS  = 2'd3
    } status_t;

    typedef struct packed {
        kind_t                      kind;
        logic signed [VALUE_W-1:0]  value;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [3:0]  position;
        logic        empty_res;
        logic [4:0]  occupancy;
    } rsp_t;

endpackage

// ----- rtl/fqs_ram.sv -----
// ----------------------------------------------------------------------------
// fqs_ram
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module fqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/fifo_queue_with_search_unit.sv -----
// ----------------------------------------------------------------------------
// fifo_queue_with_search_unit
// A bounded FIFO of signed 32-bit values kept in a DEPTH-entry ring RAM.
// Insert, remove and clear answer straight from the idle state; find walks
// the held entries from the front through the RAM read port, one entry per
// cycle, stopping at the first match or after the last held entry. Clear
// only resets the pointers, so there is no clearing pass.
// Every request yields exactly one response, held in an output register; a
// new request is taken once the previous response has been taken or is
// being taken in the same cycle.
// ----------------------------------------------------------------------------
module fifo_queue_with_search_unit #(
    parameter int DEPTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  fqs_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output fqs_pkg::rsp_t  rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } state_t;

    state_t                         state_reg, state_next;
    logic [AW-1:0]                  head_reg, head_next;
    logic [AW-1:0]                  tail_reg, tail_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [AW-1:0]                  addr_reg, addr_next;
    logic [AW-1:0]                  pos_reg, pos_next;
    logic [fqs_pkg::VALUE_W-1:0]    key_reg, key_next;
    logic                           out_valid_reg, out_valid_next;
    fqs_pkg::rsp_t                  out_reg, out_next;

    logic                           accept;
    logic                           ram_we;
    logic [AW-1:0]                  ram_raddr;
    logic [fqs_pkg::VALUE_W-1:0]    ram_rdata;

    logic                           res_load;
    fqs_pkg::status_t               res_status;
    logic [AW-1:0]                  res_pos;
    logic [CW-1:0]                  res_count;
    logic [AW+3:0]                  res_pos_wide;
    logic [CW+4:0]                  res_count_wide;
    logic [CW-1:0]                  pos_plus1;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
        logic [AW-1:0] r;
        r = (idx == LAST_IDX) ? '0 : idx + 1'b1;
        return r;
    endfunction

    fqs_ram #(
        .WIDTH (fqs_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (req.value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_stall = (state_reg != S_IDLE) || (out_valid_reg && rsp_stall);
    assign accept    = req_valid && !req_stall;
    assign ram_raddr = (state_reg == S_SEARCH) ? addr_reg : head_reg;
    assign pos_plus1 = CW'(pos_reg) + 1'b1;

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        addr_next      = addr_reg;
        pos_next       = pos_reg;
        key_next       = key_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        ram_we         = 1'b0;
        res_load       = 1'b0;
        res_status     = fqs_pkg::ST_OK;
        res_pos        = '0;
        res_count      = count_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.kind)
                        fqs_pkg::KIND_INSERT:
                        begin
                            res_load = 1'b1;
                            if (count_reg == FULL_CNT)
                            begin
                                res_status = fqs_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                tail_next  = ring_next(tail_reg);
                                count_next = count_reg + 1'b1;
                                res_count  = count_next;
                            end
                        end
                        fqs_pkg::KIND_REMOVE:
                        begin
                            res_load = 1'b1;
                            if (count_reg == '0)
                            begin
                                res_status = fqs_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                head_next  = ring_next(head_reg);
                                count_next = count_reg - 1'b1;
                                res_count  = count_next;
                            end
                        end
                        fqs_pkg::KIND_FIND:
                        begin
                            if (count_reg == '0)
                            begin
                                res_load   = 1'b1;
                                res_status = fqs_pkg::ST_MISS;
                            end
                            else
                            begin
                                // head read is issued this cycle; walk from next entry
                                state_next = S_SEARCH;
                                key_next   = req.value;
                                addr_next  = ring_next(head_reg);
                                pos_next   = '0;
                            end
                        end
                        default:
                        begin
                            res_load   = 1'b1;
                            head_next  = '0;
                            tail_next  = '0;
                            count_next = '0;
                            res_count  = '0;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                // ram_rdata holds the entry at position pos_reg
                if (ram_rdata == key_reg)
                begin
                    res_load   = 1'b1;
                    res_pos    = pos_reg;
                    state_next = S_IDLE;
                end
                else if (pos_plus1 == count_reg)
                begin
                    res_load   = 1'b1;
                    res_status = fqs_pkg::ST_MISS;
                    state_next = S_IDLE;
                end
                else
                begin
                    addr_next = ring_next(addr_reg);
                    pos_next  = pos_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res_pos_wide   = {4'b0, res_pos};
        res_count_wide = {5'b0, res_count};
        out_next       = out_reg;
        if (res_load)
        begin
            out_valid_next     = 1'b1;
            out_next.status    = res_status;
            out_next.position  = res_pos_wide[3:0];
            out_next.empty_res = (res_count == '0);
            out_next.occupancy = res_count_wide[4:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        pos_reg  <= pos_next;
        key_reg  <= key_next;
        out_reg  <= out_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("held count exceeds depth");

    a_search_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SEARCH |-> !out_valid_reg)
        else $error("response pending during search");

    a_search_pos_held: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SEARCH |-> CW'(pos_reg) < count_reg)
        else $error("search walked past held entries");

    a_search_holds_queue: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SEARCH |=> $stable(count_reg) && $stable(head_reg))
        else $error("queue changed during search");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.empty_res |-> out_reg.occupancy == '0)
        else $error("empty response with nonzero occupancy");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives insert, remove, find and clear requests into the searchable FIFO,
// mirrors the ring store in a shadow scoreboard and compares every response
// field by field. Sender bursts and receiver stalls are random, with one
// long receiver hold-off and one full drain in the middle of the run.
// ----------------------------------------------------------------------------
module testbench;

    localparam int QDEPTH     = 16;
    localparam int RAND_ITEMS = 1530;

    // Shadow copy of the ring store; predicts one response per request.
    class queue_shadow;
        logic signed [fqs_pkg::VALUE_W-1:0] slots [QDEPTH];
        int   front;
        int   back;
        int   held;
        int   errors;
        fqs_pkg::rsp_t awaited [$];

        function new();
            front  = 0;
            back   = 0;
            held   = 0;
            errors = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void note_request(fqs_pkg::req_t r);
            fqs_pkg::rsp_t want;
            int   idx;
            want        = '0;
            want.status = fqs_pkg::ST_OK;
            case (r.kind)
                fqs_pkg::KIND_INSERT:
                    if (held == QDEPTH) begin
                        want.status = fqs_pkg::ST_FULL;
                    end
                    else begin
                        slots[back] = r.value;
                        back = (back + 1) % QDEPTH;
                        held++;
                    end
                fqs_pkg::KIND_REMOVE:
                    if (held == 0) begin
                        want.status = fqs_pkg::ST_EMPTY;
                    end
                    else begin
                        front = (front + 1) % QDEPTH;
                        held--;
                    end
                fqs_pkg::KIND_FIND:
                    begin
                        want.status = fqs_pkg::ST_MISS;
                        idx = front;
                        // walk held entries only, stop at the first match
                        for (int k = 0; k < held; k++) begin
                            if (slots[idx] == r.value) begin
                                want.status   = fqs_pkg::ST_OK;
                                want.position = k[3:0];
                                break;
                            end
                            idx = (idx + 1) % QDEPTH;
                        end
                    end
                default:
                    begin
                        front = 0;
                        back  = 0;
                        held  = 0;
                    end
            endcase
            want.empty_res = (held == 0);
            want.occupancy = held[4:0];
            awaited.push_back(want);
        endfunction

        function void report_field(string field, int unsigned want, int unsigned got);
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            errors++;
        endfunction

        function void check_reply(fqs_pkg::rsp_t got);
            fqs_pkg::rsp_t want;
            if (awaited.size() == 0) begin
                $display("%0t: response expected none actual %p", $time, got);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status)
                report_field("status", int'(want.status), int'(got.status));
            if (got.position !== want.position)
                report_field("position", int'(want.position), int'(got.position));
            if (got.empty_res !== want.empty_res)
                report_field("empty_res", int'(want.empty_res), int'(got.empty_res));
            if (got.occupancy !== want.occupancy)
                report_field("occupancy", int'(want.occupancy), int'(got.occupancy));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    fqs_pkg::req_t req;
    logic rsp_valid;
    logic rsp_stall;
    fqs_pkg::rsp_t rsp;

    queue_shadow                        shadow;
    int                                 requests_taken = 0;
    logic signed [fqs_pkg::VALUE_W-1:0] value_pool [8];

    fifo_queue_with_search_unit #(
        .DEPTH(QDEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("fifo_queue_with_search_unit: mismatch");
        $finish;
    end

    // Check responses before noting requests taken at the same edge.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (rsp_valid && !rsp_stall)
                shadow.check_reply(rsp);
            if (req_valid && !req_stall) begin
                shadow.note_request(req);
                requests_taken++;
            end
        end
    end

    // Receiver: stall on random patterns, hold off once for a long stretch.
    initial
    begin : reply_side
        int  mode;
        int  run;
        bit  held_off;
        held_off = 1'b0;
        rsp_stall <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (!held_off && requests_taken >= 400) begin
                held_off = 1'b1;
                rsp_stall <= 1'b1;
                repeat (300) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            run  = $urandom_range(1, 40);
            repeat (run) begin
                case (mode)
                    0: rsp_stall <= 1'b0;
                    1: rsp_stall <= ($urandom_range(0, 3) == 0);
                    2: rsp_stall <= 1'($urandom_range(0, 1));
                    default: rsp_stall <= ($urandom_range(0, 3) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    task automatic offer(input fqs_pkg::kind_t k,
                         input logic signed [fqs_pkg::VALUE_W-1:0] v);
        fqs_pkg::req_t r;
        r.kind  = k;
        r.value = v;
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall) @(posedge clk);
    endtask

    task automatic pause(input int cycles);
        req_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Phase 0 fills, phase 1 drains, phase 2 mixes.
    function automatic fqs_pkg::kind_t pick_kind(input int phase);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            return fqs_pkg::KIND_CLEAR;
        case (phase)
            0: return (roll < 62) ? fqs_pkg::KIND_INSERT :
                      (roll < 72) ? fqs_pkg::KIND_REMOVE : fqs_pkg::KIND_FIND;
            1: return (roll < 17) ? fqs_pkg::KIND_INSERT :
                      (roll < 70) ? fqs_pkg::KIND_REMOVE : fqs_pkg::KIND_FIND;
            default: return (roll < 37) ? fqs_pkg::KIND_INSERT :
                            (roll < 67) ? fqs_pkg::KIND_REMOVE : fqs_pkg::KIND_FIND;
        endcase
    endfunction

    // Draw mostly from a small pool so finds hit and duplicates occur.
    function automatic logic signed [fqs_pkg::VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return value_pool[$urandom_range(0, 7)];
    endfunction

    initial
    begin : request_side
        int             sent;
        int             burst;
        int             phase;
        int             phase_left;
        bit             drained;
        fqs_pkg::kind_t k;
        shadow         = new();
        drained        = 1'b0;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7FFF_FFFF;
        value_pool[2] = 32'sh0000_0000;
        value_pool[3] = -32'sd1;
        for (int i = 4; i < 8; i++)
            value_pool[i] = $urandom;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty cases, extremes, first match, clear, bit patterns
        offer(fqs_pkg::KIND_REMOVE, 32'sd0);
        offer(fqs_pkg::KIND_FIND,   32'sd0);
        offer(fqs_pkg::KIND_INSERT, 32'sh8000_0000);
        offer(fqs_pkg::KIND_INSERT, 32'sh7FFF_FFFF);
        offer(fqs_pkg::KIND_INSERT, 32'sh0000_0000);
        offer(fqs_pkg::KIND_INSERT, -32'sd1);
        offer(fqs_pkg::KIND_INSERT, 32'sh7FFF_FFFF);
        offer(fqs_pkg::KIND_FIND,   32'sh7FFF_FFFF);
        offer(fqs_pkg::KIND_FIND,   -32'sd1);
        offer(fqs_pkg::KIND_FIND,   32'sh8000_0000);
        offer(fqs_pkg::KIND_FIND,   32'sd12345);
        offer(fqs_pkg::KIND_REMOVE, -32'sd1);
        offer(fqs_pkg::KIND_FIND,   32'sh8000_0000);
        offer(fqs_pkg::KIND_CLEAR,  32'sh7FFF_FFFF);
        offer(fqs_pkg::KIND_FIND,   32'sh7FFF_FFFF);
        offer(fqs_pkg::KIND_REMOVE, 32'sd0);
        offer(fqs_pkg::KIND_INSERT, 32'sh5555_5555);
        offer(fqs_pkg::KIND_INSERT, 32'shAAAA_AAAA);
        offer(fqs_pkg::KIND_FIND,   32'shAAAA_AAAA);
        offer(fqs_pkg::KIND_FIND,   32'sh5555_5555);

        sent       = 0;
        phase      = 0;
        phase_left = $urandom_range(20, 80);
        while (sent < RAND_ITEMS) begin
            burst = $urandom_range(1, 30);
            while (burst > 0 && sent < RAND_ITEMS) begin
                if (phase_left == 0) begin
                    phase      = $urandom_range(0, 2);
                    phase_left = $urandom_range(20, 80);
                    value_pool[$urandom_range(4, 7)] = $urandom;
                end
                k = pick_kind(phase);
                offer(k, pick_value());
                phase_left--;
                burst--;
                sent++;
            end
            // hold the sender once until every response is back
            if (!drained && sent >= 900) begin
                drained = 1'b1;
                req_valid <= 1'b0;
                @(posedge clk);
                while (shadow.pending() != 0) @(posedge clk);
            end
            if ($urandom_range(0, 2) != 0)
                pause($urandom_range(1, 12));
        end

        req_valid <= 1'b0;
        while (shadow.pending() != 0) @(posedge clk);
        repeat (QDEPTH + 4) @(posedge clk);
        if (shadow.errors == 0 && shadow.pending() == 0)
            $display("fifo_queue_with_search_unit: match");
        else
            $display("fifo_queue_with_search_unit: mismatch");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/fqs_pkg.sv
rtl/fqs_ram.sv
rtl/fifo_queue_with_search_unit.sv
bench/testbench.sv
